FILE: hdl/dspc_pkg.sv
// dspc_pkg: shared types and constants for the single path check block
// no dependencies
package dspc_pkg;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETTLE,
      ST_DFS_INIT,
      ST_DFS_HEAD,
      ST_DFS_EDGE,
      ST_DFS_TGT,
      ST_DFS_VIS,
      ST_DFS_POP,
      ST_DFS_CUR,
      ST_CHK_START,
      ST_CHK_FIRST,
      ST_CHK_NODE,
      ST_CHK_LIST,
      ST_CHK_EDGE,
      ST_CHK_TGT,
      ST_RESP
   } st_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;

   localparam int FIELD_W = 10;

endpackage

FILE: hdl/dag_single_path_check.sv
// Edges are taken one per cycle while busy is low and appended to per-node
// adjacency lists (one list memory, one edge target and one edge link memory).
// The item with req_last_edge ends the graph: busy rises and a settle state
// follows; then, unless an edge was out of range or did not fit, a depth-first
// search from node 0 runs through the list, stack, cursor and visited memories,
// and a check walks the finishing order against the lists. One result appears
// on rsp_valid for one cycle and cannot be held off. A clearing pass then
// resets the lists and visited marks of all nodes; it also runs after reset.
// csr writes are always taken.
// depends on dspc_pkg, dspc_ram
module dag_single_path_check #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [9:0] req_from_node,
   input  logic [9:0] req_to_node,
   input  logic       req_edge_valid,
   input  logic       req_last_edge,
   output logic       rsp_valid,
   output logic       rsp_single_path_found,
   output logic [1:0] rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [9:0] csr_node_count
);

   localparam int NW  = $clog2(MAX_NODES);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int TW  = (NW > dspc_pkg::FIELD_W) ? NW : dspc_pkg::FIELD_W;
   localparam int LW  = EW + EAW;
   localparam logic [EW-1:0] LINK_END   = EW'(MAX_EDGES);
   localparam logic [TW-1:0] NODE_LIMIT = TW'(MAX_NODES - 1);
   localparam logic [NW:0]   SP_MAX     = (NW+1)'(MAX_NODES);

   dspc_pkg::st_type st_ff, st_in;
   logic [NW-1:0]  clr_ff, clr_in;
   logic [EW-1:0]  edges_ff, edges_in;
   logic [1:0]     flags_ff, flags_in;
   logic [9:0]     node_count_ff, node_count_in;
   logic           s1_valid_ff, s1_valid_in;
   logic [NW-1:0]  s1_from_ff, s1_from_in;
   logic [NW-1:0]  s1_to_ff, s1_to_in;
   logic [EAW-1:0] s1_e_ff, s1_e_in;
   logic           fw_valid_ff, fw_valid_in;
   logic [NW-1:0]  fw_from_ff, fw_from_in;
   logic [LW-1:0]  fw_val_ff, fw_val_in;
   logic [NW-1:0]  v_ff, v_in;
   logic [EW-1:0]  e_ff, e_in;
   logic [EAW-1:0] tail_ff, tail_in;
   logic [NW-1:0]  t_ff, t_in;
   logic [NW:0]    sp_ff, sp_in;
   logic [NW:0]    cnt_ff, cnt_in;
   logic           bad_ff, bad_in;
   logic [NW:0]    j_ff, j_in;
   logic [NW-1:0]  a_ff, a_in;
   logic [NW-1:0]  b_ff, b_in;
   logic           found_ff, found_in;
   logic [1:0]     status_ff, status_in;

   logic           nl_we;
   logic [NW-1:0]  nl_waddr, nl_raddr;
   logic [LW-1:0]  nl_wdata, nl_rdata;
   logic           tg_we;
   logic [EAW-1:0] tg_waddr, edge_raddr;
   logic [NW-1:0]  tg_wdata, tg_rdata;
   logic           lk_we;
   logic [EAW-1:0] lk_waddr, lk_wdata, lk_rdata;
   logic           vis_we;
   logic [NW-1:0]  vis_waddr, vis_raddr;
   logic           vis_wdata, vis_rdata;
   logic           stk_we;
   logic [NW-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;
   logic           cur_we;
   logic [NW-1:0]  cur_waddr, cur_raddr;
   logic [LW-1:0]  cur_wdata, cur_rdata;
   logic           ord_we;
   logic [NW-1:0]  ord_waddr, ord_raddr, ord_wdata, ord_rdata;

   logic [TW-1:0]  top_n;
   logic [LW-1:0]  s1_ent, s1_new;
   logic           s1_empty;
   logic [NW:0]    sp_m2, j_p1;
   logic           range_bad;

   assign top_n = (TW'(node_count_ff) > NODE_LIMIT) ? NODE_LIMIT : TW'(node_count_ff);
   assign range_bad = (TW'(req_from_node) > top_n) || (TW'(req_to_node) > top_n);

   // list entry of the edge in flight, forwarded from the write of the previous cycle
   assign s1_ent   = (fw_valid_ff && (fw_from_ff == s1_from_ff)) ? fw_val_ff : nl_rdata;
   assign s1_empty = s1_ent[LW-1:EAW] >= LINK_END;
   assign s1_new   = s1_empty ? {EW'(s1_e_ff), s1_e_ff} : {s1_ent[LW-1:EAW], s1_e_ff};
   assign sp_m2    = sp_ff - (NW+1)'(2);
   assign j_p1     = j_ff + (NW+1)'(1);

   dspc_ram #(.DEPTH(MAX_NODES), .WIDTH(LW)) u_list (
      .clock(clock), .wr_en(nl_we), .wr_addr(nl_waddr), .wr_data(nl_wdata),
      .rd_addr(nl_raddr), .rd_data(nl_rdata));
   dspc_ram #(.DEPTH(MAX_EDGES), .WIDTH(NW)) u_target (
      .clock(clock), .wr_en(tg_we), .wr_addr(tg_waddr), .wr_data(tg_wdata),
      .rd_addr(edge_raddr), .rd_data(tg_rdata));
   dspc_ram #(.DEPTH(MAX_EDGES), .WIDTH(EAW)) u_link (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_waddr), .wr_data(lk_wdata),
      .rd_addr(edge_raddr), .rd_data(lk_rdata));
   dspc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_visited (
      .clock(clock), .wr_en(vis_we), .wr_addr(vis_waddr), .wr_data(vis_wdata),
      .rd_addr(vis_raddr), .rd_data(vis_rdata));
   dspc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata));
   dspc_ram #(.DEPTH(MAX_NODES), .WIDTH(LW)) u_cursor (
      .clock(clock), .wr_en(cur_we), .wr_addr(cur_waddr), .wr_data(cur_wdata),
      .rd_addr(cur_raddr), .rd_data(cur_rdata));
   dspc_ram #(.DEPTH(MAX_NODES), .WIDTH(NW)) u_order (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_waddr), .wr_data(ord_wdata),
      .rd_addr(ord_raddr), .rd_data(ord_rdata));

   always_comb begin
      st_in         = st_ff;
      clr_in        = clr_ff;
      edges_in      = edges_ff;
      flags_in      = flags_ff;
      node_count_in = (csr_valid && csr_ready) ? csr_node_count : node_count_ff;
      s1_valid_in   = 1'b0;
      s1_from_in    = s1_from_ff;
      s1_to_in      = s1_to_ff;
      s1_e_in       = s1_e_ff;
      fw_valid_in   = s1_valid_ff;
      fw_from_in    = s1_from_ff;
      fw_val_in     = s1_new;
      v_in          = v_ff;
      e_in          = e_ff;
      tail_in       = tail_ff;
      t_in          = t_ff;
      sp_in         = sp_ff;
      cnt_in        = cnt_ff;
      bad_in        = bad_ff;
      j_in          = j_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      found_in      = found_ff;
      status_in     = status_ff;

      nl_we      = 1'b0;
      nl_waddr   = s1_from_ff;
      nl_wdata   = s1_new;
      nl_raddr   = '0;
      tg_we      = 1'b0;
      tg_waddr   = s1_e_ff;
      tg_wdata   = s1_to_ff;
      edge_raddr = e_ff[EAW-1:0];
      lk_we      = 1'b0;
      lk_waddr   = s1_ent[EAW-1:0];
      lk_wdata   = s1_e_ff;
      vis_we     = 1'b0;
      vis_waddr  = t_ff;
      vis_wdata  = 1'b1;
      vis_raddr  = tg_rdata;
      stk_we     = 1'b0;
      stk_waddr  = sp_ff[NW-1:0];
      stk_wdata  = t_ff;
      stk_raddr  = sp_m2[NW-1:0];
      cur_we     = 1'b0;
      cur_waddr  = v_ff;
      cur_wdata  = {e_ff, tail_ff};
      cur_raddr  = stk_rdata;
      ord_we     = 1'b0;
      ord_waddr  = cnt_ff[NW-1:0];
      ord_wdata  = v_ff;
      ord_raddr  = j_ff[NW-1:0];

      // append stage of the edge taken last cycle
      if (s1_valid_ff) begin
         nl_we = 1'b1;
         tg_we = 1'b1;
         lk_we = !s1_empty;
      end

      unique case (st_ff)
         dspc_pkg::ST_CLEAR: begin
            nl_we     = 1'b1;
            nl_waddr  = clr_ff;
            nl_wdata  = {LINK_END, EAW'(0)};
            vis_we    = 1'b1;
            vis_waddr = clr_ff;
            vis_wdata = 1'b0;
            clr_in    = clr_ff + NW'(1);
            if (clr_ff == NW'(MAX_NODES - 1)) begin
               st_in = dspc_pkg::ST_IDLE;
            end
         end
         dspc_pkg::ST_IDLE: begin
            nl_raddr = NW'(req_from_node);
            if (start) begin
               if (req_edge_valid) begin
                  if (range_bad) begin
                     flags_in[1] = 1'b1;
                  end else if (edges_ff >= LINK_END) begin
                     flags_in[0] = 1'b1;
                  end else begin
                     s1_valid_in = 1'b1;
                     s1_from_in  = NW'(req_from_node);
                     s1_to_in    = NW'(req_to_node);
                     s1_e_in     = edges_ff[EAW-1:0];
                     edges_in    = edges_ff + EW'(1);
                  end
               end
               if (req_last_edge) begin
                  st_in = dspc_pkg::ST_SETTLE;
               end
            end
         end
         dspc_pkg::ST_SETTLE: begin
            if (flags_ff != 2'b00) begin
               found_in  = 1'b0;
               status_in = flags_ff[1] ? dspc_pkg::STATUS_RANGE : dspc_pkg::STATUS_OVERFLOW;
               st_in     = dspc_pkg::ST_RESP;
            end else begin
               status_in = dspc_pkg::STATUS_OK;
               st_in     = dspc_pkg::ST_DFS_INIT;
            end
         end
         dspc_pkg::ST_DFS_INIT: begin
            vis_we    = 1'b1;
            vis_waddr = '0;
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = '0;
            nl_raddr  = '0;
            v_in      = '0;
            sp_in     = (NW+1)'(1);
            cnt_in    = '0;
            bad_in    = 1'b0;
            st_in     = dspc_pkg::ST_DFS_HEAD;
         end
         dspc_pkg::ST_DFS_HEAD: begin
            e_in    = nl_rdata[LW-1:EAW];
            tail_in = nl_rdata[EAW-1:0];
            st_in   = dspc_pkg::ST_DFS_EDGE;
         end
         dspc_pkg::ST_DFS_EDGE: begin
            if (e_ff >= LINK_END) begin
               // node finished
               ord_we = 1'b1;
               cnt_in = cnt_ff + (NW+1)'(1);
               if (TW'(v_ff) > top_n) begin
                  bad_in = 1'b1;
               end
               sp_in = sp_ff - (NW+1)'(1);
               if (sp_ff == (NW+1)'(1)) begin
                  st_in = dspc_pkg::ST_CHK_START;
               end else begin
                  st_in = dspc_pkg::ST_DFS_POP;
               end
            end else begin
               st_in = dspc_pkg::ST_DFS_TGT;
            end
         end
         dspc_pkg::ST_DFS_TGT: begin
            t_in  = tg_rdata;
            e_in  = (e_ff[EAW-1:0] == tail_ff) ? LINK_END : EW'(lk_rdata);
            st_in = dspc_pkg::ST_DFS_VIS;
         end
         dspc_pkg::ST_DFS_VIS: begin
            if (!vis_rdata) begin
               vis_we   = 1'b1;
               cur_we   = 1'b1;
               stk_we   = 1'b1;
               sp_in    = sp_ff + (NW+1)'(1);
               v_in     = t_ff;
               nl_raddr = t_ff;
               st_in    = dspc_pkg::ST_DFS_HEAD;
            end else begin
               st_in = dspc_pkg::ST_DFS_EDGE;
            end
         end
         dspc_pkg::ST_DFS_POP: begin
            v_in  = stk_rdata;
            st_in = dspc_pkg::ST_DFS_CUR;
         end
         dspc_pkg::ST_DFS_CUR: begin
            e_in    = cur_rdata[LW-1:EAW];
            tail_in = cur_rdata[EAW-1:0];
            st_in   = dspc_pkg::ST_DFS_EDGE;
         end
         dspc_pkg::ST_CHK_START: begin
            if (bad_ff || ((TW+1)'(cnt_ff) != ((TW+1)'(top_n) + (TW+1)'(1)))) begin
               found_in = 1'b0;
               st_in    = dspc_pkg::ST_RESP;
            end else if (cnt_ff == (NW+1)'(1)) begin
               found_in = 1'b1;
               st_in    = dspc_pkg::ST_RESP;
            end else begin
               ord_raddr = '0;
               j_in      = (NW+1)'(1);
               st_in     = dspc_pkg::ST_CHK_FIRST;
            end
         end
         dspc_pkg::ST_CHK_FIRST: begin
            b_in  = ord_rdata;
            st_in = dspc_pkg::ST_CHK_NODE;
         end
         dspc_pkg::ST_CHK_NODE: begin
            a_in     = ord_rdata;
            nl_raddr = ord_rdata;
            st_in    = dspc_pkg::ST_CHK_LIST;
         end
         dspc_pkg::ST_CHK_LIST: begin
            if (nl_rdata[LW-1:EAW] >= LINK_END) begin
               found_in = 1'b0;
               st_in    = dspc_pkg::ST_RESP;
            end else begin
               e_in    = nl_rdata[LW-1:EAW];
               tail_in = nl_rdata[EAW-1:0];
               st_in   = dspc_pkg::ST_CHK_EDGE;
            end
         end
         dspc_pkg::ST_CHK_EDGE: begin
            st_in = dspc_pkg::ST_CHK_TGT;
         end
         dspc_pkg::ST_CHK_TGT: begin
            if (tg_rdata == b_ff) begin
               if (j_p1 == cnt_ff) begin
                  found_in = 1'b1;
                  st_in    = dspc_pkg::ST_RESP;
               end else begin
                  b_in      = a_ff;
                  j_in      = j_p1;
                  ord_raddr = j_p1[NW-1:0];
                  st_in     = dspc_pkg::ST_CHK_NODE;
               end
            end else if (e_ff[EAW-1:0] == tail_ff) begin
               found_in = 1'b0;
               st_in    = dspc_pkg::ST_RESP;
            end else begin
               e_in  = EW'(lk_rdata);
               st_in = dspc_pkg::ST_CHK_EDGE;
            end
         end
         dspc_pkg::ST_RESP: begin
            clr_in   = '0;
            edges_in = '0;
            flags_in = 2'b00;
            st_in    = dspc_pkg::ST_CLEAR;
         end
         default: begin
            st_in = dspc_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= dspc_pkg::ST_CLEAR;
         clr_ff        <= '0;
         edges_ff      <= '0;
         flags_ff      <= 2'b00;
         node_count_ff <= '0;
         s1_valid_ff   <= 1'b0;
         fw_valid_ff   <= 1'b0;
      end else begin
         st_ff         <= st_in;
         clr_ff        <= clr_in;
         edges_ff      <= edges_in;
         flags_ff      <= flags_in;
         node_count_ff <= node_count_in;
         s1_valid_ff   <= s1_valid_in;
         fw_valid_ff   <= fw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_from_ff <= s1_from_in;
      s1_to_ff   <= s1_to_in;
      s1_e_ff    <= s1_e_in;
      fw_from_ff <= fw_from_in;
      fw_val_ff  <= fw_val_in;
      v_ff       <= v_in;
      e_ff       <= e_in;
      tail_ff    <= tail_in;
      t_ff       <= t_in;
      sp_ff      <= sp_in;
      cnt_ff     <= cnt_in;
      bad_ff     <= bad_in;
      j_ff       <= j_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
   end

   assign busy                  = st_ff != dspc_pkg::ST_IDLE;
   assign csr_ready             = 1'b1;
   assign rsp_valid             = st_ff == dspc_pkg::ST_RESP;
   assign rsp_single_path_found = found_ff;
   assign rsp_status            = status_ff;

   a_found_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_single_path_found && (rsp_status != dspc_pkg::STATUS_OK)))
      else $error("path reported with error status");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == dspc_pkg::ST_DFS_EDGE) |-> (sp_ff <= SP_MAX))
      else $error("search stack beyond depth");

   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      edges_ff <= LINK_END)
      else $error("edge count beyond store");

   a_append_after_transfer: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(start && !busy && req_edge_valid))
      else $error("append without input transfer");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (busy && (st_ff == dspc_pkg::ST_CLEAR)))
      else $error("no clearing pass after result");

endmodule

FILE: hdl/dspc_ram.sv
// dspc_ram: simple dual port synchronous ram, one write and one read port
// read data registered; no dependencies
module dspc_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/dag_single_path_check_test.sv
// dag_single_path_check_test: self-checking bench for the single path check block
// drives edge graphs through the command port, predicts each answer in-house
// depends on dspc_pkg and dag_single_path_check
module dag_single_path_check_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = 1024;
   localparam int EDGES = 4096;
   localparam int LINK_NONE = EDGES;
   localparam int ITEM_GOAL = 1650;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      bit         set_count;
      bit [9:0]   count_val;
      bit [9:0]   from_node;
      bit [9:0]   to_node;
      bit         edge_valid;
      bit         last_edge;
      bit         known;
      bit         found;
      logic [1:0] status;
   } edge_item_type;

   typedef struct {
      bit         found;
      logic [1:0] status;
   } answer_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [9:0] req_from_node;
   logic [9:0] req_to_node;
   logic       req_edge_valid;
   logic       req_last_edge;
   logic       rsp_valid;
   logic       rsp_single_path_found;
   logic [1:0] rsp_status;
   logic       csr_valid;
   logic       csr_ready;
   logic [9:0] csr_node_count;

   dag_single_path_check DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_from_node(req_from_node), .req_to_node(req_to_node),
      .req_edge_valid(req_edge_valid), .req_last_edge(req_last_edge),
      .rsp_valid(rsp_valid), .rsp_single_path_found(rsp_single_path_found),
      .rsp_status(rsp_status), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_node_count(csr_node_count)
   );

   // shadow graph state
   int       top_node;
   int       list_first[NODES];
   int       list_last[NODES];
   int       edge_dest[EDGES];
   int       edge_next[EDGES];
   int       edge_total;
   bit [1:0] err_bits;
   bit       seen[NODES];
   int       dfs_stack[NODES];
   int       dfs_cursor[NODES];
   int       finish_order[NODES];

   answer_type    answers_due[$];
   edge_item_type graph_items[$];
   int            fail_count;
   int            items_sent;
   longint        cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void graph_clear();
      for (int i = 0; i < NODES; i++) begin
         list_first[i] = LINK_NONE;
         list_last[i] = LINK_NONE;
         seen[i] = 1'b0;
      end
      edge_total = 0;
      err_bits = 2'b00;
   endfunction

   function automatic void graph_add(int src, int dst);
      int e;
      if (src > top_node || dst > top_node) begin
         err_bits |= 2'b10;
         return;
      end
      if (edge_total >= EDGES) begin
         err_bits |= 2'b01;
         return;
      end
      e = edge_total++;
      edge_dest[e] = dst;
      edge_next[e] = LINK_NONE;
      if (list_first[src] == LINK_NONE) list_first[src] = e;
      else edge_next[list_last[src]] = e;
      list_last[src] = e;
   endfunction

   function automatic bit graph_linked(int src, int dst);
      int e;
      e = list_first[src];
      while (e < EDGES) begin
         if (edge_dest[e] == dst) return 1'b1;
         e = edge_next[e];
      end
      return 1'b0;
   endfunction

   function automatic bit path_covers_all();
      int sp;
      int cnt;
      int v;
      int e;
      int t;
      bit pushed;
      sp = 0;
      cnt = 0;
      for (int i = 0; i < NODES; i++) begin
         seen[i] = 1'b0;
         dfs_cursor[i] = list_first[i];
      end
      seen[0] = 1'b1;
      dfs_stack[sp++] = 0;
      while (sp > 0) begin
         v = dfs_stack[sp - 1];
         e = dfs_cursor[v];
         pushed = 1'b0;
         while (e < EDGES) begin
            t = edge_dest[e] % NODES;
            e = edge_next[e];
            if (!seen[t] && sp < NODES) begin
               seen[t] = 1'b1;
               dfs_stack[sp++] = t;
               pushed = 1'b1;
               break;
            end
         end
         dfs_cursor[v] = e;
         if (!pushed) begin
            sp--;
            if (cnt < NODES) finish_order[cnt++] = v;
         end
      end
      if (cnt != top_node + 1) return 1'b0;
      for (int i = 0; i < cnt; i++)
         if (finish_order[i] > top_node) return 1'b0;
      for (int i = 0; i + 1 < cnt; i++)
         if (!graph_linked(finish_order[i + 1], finish_order[i])) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void predict_answer(edge_item_type it);
      answer_type a;
      if (it.edge_valid) graph_add(int'(it.from_node), int'(it.to_node));
      if (!it.last_edge) return;
      if (err_bits[1]) a.status = dspc_pkg::STATUS_RANGE;
      else if (err_bits[0]) a.status = dspc_pkg::STATUS_OVERFLOW;
      else a.status = dspc_pkg::STATUS_OK;
      a.found = (a.status == dspc_pkg::STATUS_OK) ? path_covers_all() : 1'b0;
      graph_clear();
      if (it.known) begin
         a.found = it.found;
         a.status = it.status;
      end
      answers_due.push_back(a);
   endfunction

   function automatic bit gap_now();
      if (items_sent >= 600 && items_sent < 1000) return 1'b0;
      return $urandom_range(0, 99) < 6;
   endfunction

   task automatic write_node_count(bit [9:0] val);
      start <= 1'b0;
      wait (answers_due.size() == 0);
      repeat (4) @(posedge clock);
      while (gap_now()) @(posedge clock);
      csr_valid <= 1'b1;
      csr_node_count <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      top_node = int'(val);
   endtask

   task automatic send_item(edge_item_type it);
      if (it.set_count) write_node_count(it.count_val);
      if (gap_now()) begin
         start <= 1'b0;
         do @(posedge clock); while (gap_now());
      end
      start <= 1'b1;
      req_from_node <= it.from_node;
      req_to_node <= it.to_node;
      req_edge_valid <= it.edge_valid;
      req_last_edge <= it.last_edge;
      do @(posedge clock); while (busy);
      predict_answer(it);
      items_sent++;
   endtask

   function automatic edge_item_type mk(bit sc, int cv, int f, int t, bit v, bit l,
                                        bit k = 0, bit fd = 0,
                                        logic [1:0] st = dspc_pkg::STATUS_OK);
      edge_item_type it;
      it.set_count = sc;
      it.count_val = 10'(cv);
      it.from_node = 10'(f);
      it.to_node = 10'(t);
      it.edge_valid = v;
      it.last_edge = l;
      it.known = k;
      it.found = fd;
      it.status = st;
      return it;
   endfunction

   function automatic int pick_size();
      if ($urandom_range(0, 99) < 3) return $urandom_range(100, 250);
      return $urandom_range(1, 12);
   endfunction

   // builds one graph: mostly a shuffled hamiltonian path with extra forward edges
   function automatic void build_graph();
      int n;
      int perm[$];
      int j;
      int tmp;
      int extra;
      int a;
      int b;
      edge_item_type list[$];
      n = pick_size();
      graph_items.delete();
      if ($urandom_range(0, 99) < 65) begin
         for (int i = 1; i <= n; i++) perm.push_back(i);
         perm.shuffle();
         perm.push_front(0);
         for (int i = 0; i < n; i++) list.push_back(mk(0, 0, perm[i], perm[i + 1], 1, 0));
         extra = $urandom_range(0, n);
         for (int i = 0; i < extra; i++) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(a + 1, n);
            list.push_back(mk(0, 0, perm[a], perm[b], 1, 0));
         end
         list.shuffle();
         if ($urandom_range(0, 99) < 10) list.delete($urandom_range(0, list.size() - 1));
         if ($urandom_range(0, 99) < 5)
            list.push_back(mk(0, 0, $urandom_range(0, n), $urandom_range(n + 1, 1023), 1, 0));
      end else begin
         if ($urandom_range(0, 99) < 4) n = 1023;
         tmp = $urandom_range(0, 15);
         for (int i = 0; i < tmp; i++) begin
            if ($urandom_range(0, 99) < 15)
               list.push_back(mk(0, 0, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                 1'($urandom_range(0, 1)), 0));
            else
               list.push_back(mk(0, 0, $urandom_range(0, n), $urandom_range(0, n), 1, 0));
         end
         if (list.size() > 1 && $urandom_range(0, 99) < 15) begin
            j = $urandom_range(1, list.size() - 1);
            list[j].set_count = 1'b1;
            list[j].count_val = 10'($urandom_range(0, n));
         end
      end
      if (list.size() == 0 || $urandom_range(0, 1)) list.push_back(mk(0, 0, 0, 0, 0, 1));
      else list[list.size() - 1].last_edge = 1'b1;
      list[0].set_count = 1'b1;
      list[0].count_val = 10'(n);
      graph_items = list;
   endfunction

   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected transfer found=%0b status=%0d", $realtime,
                     rsp_single_path_found, rsp_status);
            fail_count++;
         end else begin
            a = answers_due.pop_front();
            if (rsp_single_path_found !== a.found) begin
               $display("%0t: found expected %0b actual %0b", $realtime, a.found,
                        rsp_single_path_found);
               fail_count++;
            end
            if (rsp_status !== a.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime, a.status,
                        rsp_status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      edge_item_type directed[$];
      fail_count = 0;
      items_sent = 0;
      cycle_count = 0;
      top_node = 0;
      graph_clear();
      reset <= 1'b1;
      start <= 1'b0;
      req_from_node <= '0;
      req_to_node <= '0;
      req_edge_valid <= 1'b0;
      req_last_edge <= 1'b0;
      csr_valid <= 1'b0;
      csr_node_count <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      directed = '{
         mk(0, 0, 0, 0, 0, 1, 1, 1, dspc_pkg::STATUS_OK),
         mk(1, 1, 0, 1, 1, 1, 1, 1, dspc_pkg::STATUS_OK),
         mk(0, 0, 0, 2, 1, 1, 1, 0, dspc_pkg::STATUS_RANGE),
         mk(1, 1023, 1023, 1023, 1, 1, 1, 0, dspc_pkg::STATUS_OK),
         mk(1, 2, 0, 1, 1, 0),
         mk(0, 0, 1, 2, 1, 0),
         mk(0, 0, 0, 2, 1, 1),
         mk(1, 3, 0, 3, 1, 0),
         mk(1, 2, 0, 0, 0, 1),
         mk(0, 0, 1023, 0, 1, 0),
         mk(0, 0, 0, 1, 1, 1, 1, 0, dspc_pkg::STATUS_RANGE),
         mk(0, 0, 2, 1, 1, 0),
         mk(0, 0, 0, 2, 1, 0),
         mk(0, 0, 1023, 1023, 0, 0),
         mk(0, 0, 0, 1, 1, 1)
      };
      foreach (directed[i]) send_item(directed[i]);

      // edge store overflow: one more edge than the store holds
      send_item(mk(1, 1, 0, 1, 1, 0));
      for (int i = 1; i < EDGES; i++) send_item(mk(0, 0, 0, 1, 1, 0));
      send_item(mk(0, 0, 0, 1, 1, 1, 1, 0, dspc_pkg::STATUS_OVERFLOW));
      items_sent = 0;

      while (items_sent < ITEM_GOAL) begin
         build_graph();
         foreach (graph_items[i]) send_item(graph_items[i]);
      end
      start <= 1'b0;
      wait (answers_due.size() == 0);
      repeat (2000) @(posedge clock);
      if (fail_count == 0 && answers_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
